FILE: rtl/core/fose_pkg.sv
// Shared types and constants of the fixation offset and spread estimator.
// No dependencies; used by fixation_offset_spread_estimator_unit.
`default_nettype none

package fose_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_SAMPLE   = 2'd0;
  localparam logic [1:0] FUNC_SELECT   = 2'd1;
  localparam logic [1:0] FUNC_ESTIMATE = 2'd2;
  localparam logic [1:0] FUNC_CLEAR    = 2'd3;

  // Fixed field widths
  localparam int unsigned LENW  = 24;        // length fields, Q16.8
  localparam int unsigned CNTW  = 16;        // selection count
  localparam int unsigned SUMW  = 40;        // running sums
  localparam int unsigned CAPW  = 48;        // scaled quotients cap at 2^48
  localparam int unsigned SQIW  = 50;        // square root operand
  localparam int unsigned ROOTW = 25;        // square root result
  localparam int unsigned SQRW  = 28;        // square root partial remainder
  localparam int unsigned STEPW = 6;         // iteration counter

  localparam logic [LENW-1:0] LEN_MAX      = '1;
  localparam logic [CNTW-1:0] CNT_MAX      = '1;
  localparam logic [5:0]      WIN_LEN_RST  = 6'd20;
  localparam logic [2:0]      ADDR_WIN_LEN = 3'd0;

  // Sequencer states, one-hot
  typedef enum logic [17:0] {
    ST_IDLE    = 18'b000000000000000001,
    ST_SCAN    = 18'b000000000000000010,
    ST_MUL_N   = 18'b000000000000000100,
    ST_ABS     = 18'b000000000000001000,
    ST_SQ_X    = 18'b000000000000010000,
    ST_SQ_Y    = 18'b000000000000100000,
    ST_VAR_A   = 18'b000000000001000000,
    ST_VAR_B   = 18'b000000000010000000,
    ST_SPR_A   = 18'b000000000100000000,
    ST_SPR_B   = 18'b000000001000000000,
    ST_DIV_LD  = 18'b000000010000000000,
    ST_DIV     = 18'b000000100000000000,
    ST_DIV_END = 18'b000001000000000000,
    ST_SQ_LD   = 18'b000010000000000000,
    ST_SQ      = 18'b000100000000000000,
    ST_SQ_END  = 18'b001000000000000000,
    ST_ACC     = 18'b010000000000000000,
    ST_OUT     = 18'b100000000000000000
  } state_e;

  // Which quantity the shared divider and square root are working on
  typedef enum logic [2:0] {
    PH_OFF  = 3'd0,
    PH_VX   = 3'd1,
    PH_VY   = 3'd2,
    PH_SPR  = 3'd3,
    PH_EOFF = 3'd4,
    PH_ESPR = 3'd5
  } phase_e;

endpackage

`default_nettype wire

FILE: rtl/core/fixation_offset_spread_estimator_unit.sv
// Top level of the fixation offset and spread estimator.
// Depends on fose_pkg; holds the gaze window memory and the sequencer.
`default_nettype none

// Keeps a ring of the latest gaze points in a one-port-write, one-port-read
// synchronous memory. A gaze sample or a clear word leaves the sequencer
// idle. A target selection reads the window one point per cycle, then runs
// three 48-step restoring divisions and four 25-step square roots on one
// shared divider and one shared root unit. An estimate runs two 40-step
// divisions. An empty window or an estimate with no selections goes straight
// to the output state. The input is taken only while the sequencer is idle;
// a finished result waits in the output register while the next word is
// taken. window_length is written through the APB port at byte address 0
// and is read back there.
module fixation_offset_spread_estimator_unit #(
  parameter int unsigned MAX_WINDOW = 32,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  // input words
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire  [1:0]          func_i,
  input  wire  signed [15:0]  coord_x_i,
  input  wire  signed [15:0]  coord_y_i,
  // result words
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output logic                ok_o,
  output logic [23:0]         offset_length_o,
  output logic [23:0]         spread_length_o,
  output logic [15:0]         point_count_o,
  // configuration
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [2:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int unsigned IW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int unsigned NW   = $clog2(MAX_WINDOW + 1);
  localparam int unsigned CW   = (NW > 6) ? NW : 6;
  localparam int unsigned SW   = 16 + NW;            // signed coordinate sums
  localparam int unsigned QW   = 30 + NW;            // sums of squares
  localparam int unsigned AW   = SW;                 // offset magnitudes
  localparam int unsigned TW   = (2 * AW + 1 > fose_pkg::SQIW) ? 2 * AW + 1
                                                               : fose_pkg::SQIW;
  localparam int unsigned DENW = (2 * NW > fose_pkg::CNTW) ? 2 * NW : fose_pkg::CNTW;
  localparam int unsigned DXW  = TW + 2 * FRAC_BITS + fose_pkg::CAPW;

  // ---------------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------------
  logic [5:0] win_len_q;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr == fose_pkg::ADDR_WIN_LEN);

  always_comb begin
    prdata = '0;
    if (paddr == fose_pkg::ADDR_WIN_LEN) begin
      prdata = {26'd0, win_len_q};
    end
  end

  // effective window length: zero acts as one, clamped to storage depth
  logic [CW-1:0] win_len_ext;
  logic [NW-1:0] eff_len;

  assign win_len_ext = CW'(win_len_q);

  always_comb begin
    if (win_len_q == 6'd0) begin
      eff_len = NW'(1);
    end else if (win_len_ext > CW'(MAX_WINDOW)) begin
      eff_len = NW'(MAX_WINDOW);
    end else begin
      eff_len = win_len_ext[NW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  fose_pkg::state_e state_q, state_d;
  fose_pkg::phase_e phase_q;

  logic [IW-1:0]             head_q;
  logic [NW-1:0]             fill_q;
  logic [fose_pkg::SUMW-1:0] off_sum_q, spr_sum_q;
  logic [fose_pkg::CNTW-1:0] count_q;

  logic in_acc, out_acc, out_free;

  assign in_ready_o = (state_q == fose_pkg::ST_IDLE);
  assign in_acc     = in_valid_i & in_ready_o;
  assign out_acc    = out_valid_o & out_ready_i;
  assign out_free   = ~out_valid_o | out_ready_i;

  function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] p);
    ring_inc = (p == IW'(MAX_WINDOW - 1)) ? '0 : p + IW'(1);
  endfunction

  // ---------------------------------------------------------------------------
  // Gaze sample bookkeeping: write slot and new head / fill
  // ---------------------------------------------------------------------------
  logic [NW:0]   slot_sum;
  logic [IW-1:0] wr_addr, head1, head2;
  logic [NW-1:0] fill1, fill2;
  logic          fill_room;

  assign fill_room = fill_q < NW'(MAX_WINDOW);
  assign slot_sum  = (NW+1)'(head_q) + (NW+1)'(fill_q);

  always_comb begin
    if (!fill_room) begin
      wr_addr = head_q;
    end else if (slot_sum >= (NW+1)'(MAX_WINDOW)) begin
      wr_addr = IW'(slot_sum - (NW+1)'(MAX_WINDOW));
    end else begin
      wr_addr = slot_sum[IW-1:0];
    end
    fill1 = fill_room ? fill_q + NW'(1) : fill_q;
    head1 = fill_room ? head_q : ring_inc(head_q);
    if (fill1 > eff_len) begin
      head2 = ring_inc(head1);
      fill2 = fill1 - NW'(1);
    end else begin
      head2 = head1;
      fill2 = fill1;
    end
  end

  // ---------------------------------------------------------------------------
  // Window memory: x in the low half, y in the high half
  // ---------------------------------------------------------------------------
  logic [31:0]   win_mem_q [MAX_WINDOW];
  logic [31:0]   rdata_q;
  logic [IW-1:0] rptr_q;
  logic          mem_we;

  assign mem_we = in_acc & (func_i == fose_pkg::FUNC_SAMPLE);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      win_mem_q[wr_addr] <= {coord_y_i, coord_x_i};
    end
    rdata_q <= win_mem_q[rptr_q];
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic signed [15:0]     tx_q, ty_q;
  logic [NW-1:0]          iss_q;
  logic                   rd_v_q, sq_v_q;
  logic signed [SW-1:0]   sx_q, sy_q, ntx_q, nty_q;
  logic [QW-1:0]          qx_q, qy_q;
  logic [30:0]            sqx_q, sqy_q;
  logic [2*NW-1:0]        n2_q;
  logic [AW-1:0]          axo_q, ayo_q;
  logic [TW-1:0]          t_q;

  // shared divider
  logic [fose_pkg::CAPW-1:0]  dsh_q, quo_q;
  logic [DENW-1:0]            rem_q, den_q;
  logic                       dsat_q;
  logic [fose_pkg::STEPW-1:0] step_q;

  // shared square root
  logic [fose_pkg::SQIW-1:0]  sqv_q;
  logic [fose_pkg::SQRW-1:0]  sqrem_q;
  logic [fose_pkg::ROOTW-1:0] root_q;

  logic [fose_pkg::LENW-1:0]  off_q, spr_q, eoff_q;
  logic [fose_pkg::ROOTW-1:0] sdx_q, sdy_q;

  logic                       res_ok_q;
  logic [fose_pkg::LENW-1:0]  res_off_q, res_spr_q;
  logic [fose_pkg::CNTW-1:0]  res_cnt_q;

  // scan pipeline
  logic                 rd_issue;
  logic signed [15:0]   px, py;
  assign rd_issue = (state_q == fose_pkg::ST_SCAN) && (iss_q < fill_q);
  assign px       = rdata_q[15:0];
  assign py       = rdata_q[31:16];

  function automatic logic signed [SW-1:0] tx_sum_sel(input logic sel_y);
    tx_sum_sel = sel_y ? sy_q : sx_q;
  endfunction

  // offset differences
  logic signed [SW:0] dxo, dyo;
  assign dxo = (SW+1)'(ntx_q) - (SW+1)'(tx_sum_sel(1'b0));
  assign dyo = (SW+1)'(nty_q) - (SW+1)'(tx_sum_sel(1'b1));

  // variance terms by axis
  logic [QW-1:0]          q_sel;
  logic signed [SW-1:0]   s_sel;
  logic signed [2*SW-1:0] s_sq;
  assign q_sel = (phase_q == fose_pkg::PH_VX) ? qx_q : qy_q;
  assign s_sel = (phase_q == fose_pkg::PH_VX) ? sx_q : sy_q;
  assign s_sq  = s_sel * s_sel;

  // divider load and step
  logic [DXW-1:0]  dfull, dhi;
  logic            dsat_ld;
  logic [DENW:0]   dr2;
  logic            dge;
  assign dfull   = DXW'(t_q) << (2 * FRAC_BITS);
  assign dhi     = dfull >> fose_pkg::CAPW;
  assign dsat_ld = dhi >= DXW'(n2_q);
  assign dr2     = {rem_q, dsh_q[fose_pkg::CAPW-1]};
  assign dge     = dr2 >= {1'b0, den_q};

  // square root step
  logic [fose_pkg::SQRW-1:0] sr2, strial;
  logic                      sge;
  assign sr2    = {sqrem_q[fose_pkg::SQRW-3:0], sqv_q[fose_pkg::SQIW-1 -: 2]};
  assign strial = fose_pkg::SQRW'({root_q, 2'b01});
  assign sge    = sr2 >= strial;

  function automatic logic [fose_pkg::LENW-1:0] sat_root(
    input logic [fose_pkg::ROOTW-1:0] r
  );
    sat_root = r[fose_pkg::ROOTW-1] ? fose_pkg::LEN_MAX : r[fose_pkg::LENW-1:0];
  endfunction

  logic [fose_pkg::LENW-1:0] quo_len;
  assign quo_len = (quo_q > fose_pkg::CAPW'(fose_pkg::LEN_MAX)) ? fose_pkg::LEN_MAX
                                                                : quo_q[fose_pkg::LENW-1:0];

  logic cnt_room;
  assign cnt_room = count_q != fose_pkg::CNT_MAX;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fose_pkg::ST_IDLE: begin
        if (in_acc) begin
          unique case (func_i)
            fose_pkg::FUNC_SELECT: begin
              state_d = (fill_q == '0) ? fose_pkg::ST_OUT : fose_pkg::ST_SCAN;
            end
            fose_pkg::FUNC_ESTIMATE: begin
              state_d = (count_q == '0) ? fose_pkg::ST_OUT : fose_pkg::ST_DIV_LD;
            end
            default: state_d = fose_pkg::ST_IDLE;
          endcase
        end
      end
      fose_pkg::ST_SCAN: begin
        if (!rd_issue && !rd_v_q && !sq_v_q) state_d = fose_pkg::ST_MUL_N;
      end
      fose_pkg::ST_MUL_N:   state_d = fose_pkg::ST_ABS;
      fose_pkg::ST_ABS:     state_d = fose_pkg::ST_SQ_X;
      fose_pkg::ST_SQ_X:    state_d = fose_pkg::ST_SQ_Y;
      fose_pkg::ST_SQ_Y:    state_d = fose_pkg::ST_DIV_LD;
      fose_pkg::ST_VAR_A:   state_d = fose_pkg::ST_VAR_B;
      fose_pkg::ST_VAR_B:   state_d = fose_pkg::ST_DIV_LD;
      fose_pkg::ST_SPR_A:   state_d = fose_pkg::ST_SPR_B;
      fose_pkg::ST_SPR_B:   state_d = fose_pkg::ST_SQ_LD;
      fose_pkg::ST_DIV_LD:  state_d = fose_pkg::ST_DIV;
      fose_pkg::ST_DIV: begin
        if (step_q == fose_pkg::STEPW'(1)) state_d = fose_pkg::ST_DIV_END;
      end
      fose_pkg::ST_DIV_END: begin
        if (phase_q == fose_pkg::PH_EOFF) begin
          state_d = fose_pkg::ST_DIV_LD;
        end else if (phase_q == fose_pkg::PH_ESPR) begin
          state_d = fose_pkg::ST_OUT;
        end else begin
          state_d = fose_pkg::ST_SQ_LD;
        end
      end
      fose_pkg::ST_SQ_LD:   state_d = fose_pkg::ST_SQ;
      fose_pkg::ST_SQ: begin
        if (step_q == fose_pkg::STEPW'(1)) state_d = fose_pkg::ST_SQ_END;
      end
      fose_pkg::ST_SQ_END: begin
        case (phase_q)
          fose_pkg::PH_OFF, fose_pkg::PH_VX: state_d = fose_pkg::ST_VAR_A;
          fose_pkg::PH_VY:                   state_d = fose_pkg::ST_SPR_A;
          default:                           state_d = fose_pkg::ST_ACC;
        endcase
      end
      fose_pkg::ST_ACC:     state_d = fose_pkg::ST_OUT;
      fose_pkg::ST_OUT: begin
        if (out_free) state_d = fose_pkg::ST_IDLE;
      end
      default:              state_d = fose_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fose_pkg::ST_IDLE;
      phase_q     <= fose_pkg::PH_OFF;
      win_len_q   <= fose_pkg::WIN_LEN_RST;
      head_q      <= '0;
      fill_q      <= '0;
      off_sum_q   <= '0;
      spr_sum_q   <= '0;
      count_q     <= '0;
      out_valid_o <= 1'b0;
      rd_v_q      <= 1'b0;
      sq_v_q      <= 1'b0;
    end else begin
      state_q <= state_d;
      rd_v_q  <= rd_issue;
      sq_v_q  <= rd_v_q;
      if (cfg_we) win_len_q <= pwdata[5:0];
      if (state_q == fose_pkg::ST_OUT && out_free) begin
        out_valid_o <= 1'b1;
      end else if (out_acc) begin
        out_valid_o <= 1'b0;
      end
      if (in_acc) begin
        unique case (func_i)
          fose_pkg::FUNC_SAMPLE: begin
            head_q <= head2;
            fill_q <= fill2;
          end
          fose_pkg::FUNC_SELECT:   phase_q <= fose_pkg::PH_OFF;
          fose_pkg::FUNC_ESTIMATE: phase_q <= fose_pkg::PH_EOFF;
          fose_pkg::FUNC_CLEAR: begin
            head_q    <= '0;
            fill_q    <= '0;
            off_sum_q <= '0;
            spr_sum_q <= '0;
            count_q   <= '0;
          end
          default: ;
        endcase
      end
      if (state_q == fose_pkg::ST_DIV_END && phase_q == fose_pkg::PH_EOFF) begin
        phase_q <= fose_pkg::PH_ESPR;
      end
      if (state_q == fose_pkg::ST_SQ_END) begin
        case (phase_q)
          fose_pkg::PH_OFF: phase_q <= fose_pkg::PH_VX;
          fose_pkg::PH_VX:  phase_q <= fose_pkg::PH_VY;
          fose_pkg::PH_VY:  phase_q <= fose_pkg::PH_SPR;
          default: ;
        endcase
      end
      if (state_q == fose_pkg::ST_ACC && cnt_room) begin
        off_sum_q <= off_sum_q + fose_pkg::SUMW'(off_q);
        spr_sum_q <= spr_sum_q + fose_pkg::SUMW'(spr_q);
        count_q   <= count_q + fose_pkg::CNTW'(1);
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (state_q == fose_pkg::ST_OUT && out_free) begin
      ok_o            <= res_ok_q;
      offset_length_o <= res_off_q;
      spread_length_o <= res_spr_q;
      point_count_o   <= res_cnt_q;
    end

    // window scan: read, square, accumulate
    if (rd_issue) begin
      rptr_q <= ring_inc(rptr_q);
      iss_q  <= iss_q + NW'(1);
    end
    if (rd_v_q) begin
      sx_q  <= sx_q + SW'(px);
      sy_q  <= sy_q + SW'(py);
      sqx_q <= 31'(px * px);
      sqy_q <= 31'(py * py);
    end
    if (sq_v_q) begin
      qx_q <= qx_q + QW'(sqx_q);
      qy_q <= qy_q + QW'(sqy_q);
    end

    unique case (state_q)
      fose_pkg::ST_IDLE: begin
        if (in_acc) begin
          tx_q   <= coord_x_i;
          ty_q   <= coord_y_i;
          rptr_q <= head_q;
          iss_q  <= '0;
          sx_q   <= '0;
          sy_q   <= '0;
          qx_q   <= '0;
          qy_q   <= '0;
          // early answers: empty window or no selections yet
          res_ok_q  <= 1'b0;
          res_off_q <= '0;
          res_spr_q <= '0;
          res_cnt_q <= (func_i == fose_pkg::FUNC_SELECT) ? count_q : '0;
        end
      end
      fose_pkg::ST_MUL_N: begin
        ntx_q <= SW'($signed({1'b0, fill_q})) * SW'(tx_q);
        nty_q <= SW'($signed({1'b0, fill_q})) * SW'(ty_q);
        n2_q  <= (2*NW)'(fill_q) * (2*NW)'(fill_q);
      end
      fose_pkg::ST_ABS: begin
        axo_q <= dxo[SW] ? AW'(-dxo) : AW'(dxo);
        ayo_q <= dyo[SW] ? AW'(-dyo) : AW'(dyo);
      end
      fose_pkg::ST_SQ_X:  t_q <= TW'(axo_q) * TW'(axo_q);
      fose_pkg::ST_SQ_Y:  t_q <= t_q + TW'(ayo_q) * TW'(ayo_q);
      fose_pkg::ST_VAR_A: t_q <= TW'(fill_q) * TW'(q_sel);
      fose_pkg::ST_VAR_B: t_q <= t_q - TW'($unsigned(s_sq));
      fose_pkg::ST_SPR_A: t_q <= TW'(sdx_q) * TW'(sdx_q);
      fose_pkg::ST_SPR_B: t_q <= t_q + TW'(sdy_q) * TW'(sdy_q);
      fose_pkg::ST_DIV_LD: begin
        quo_q <= '0;
        if (phase_q == fose_pkg::PH_EOFF || phase_q == fose_pkg::PH_ESPR) begin
          dsh_q  <= fose_pkg::CAPW'((phase_q == fose_pkg::PH_EOFF) ? off_sum_q : spr_sum_q)
                    << (fose_pkg::CAPW - fose_pkg::SUMW);
          rem_q  <= '0;
          den_q  <= DENW'(count_q);
          dsat_q <= 1'b0;
          step_q <= fose_pkg::STEPW'(fose_pkg::SUMW);
        end else begin
          // scaled quotient floor(t * 2^2F / n^2), capped at 2^48
          dsh_q  <= dfull[fose_pkg::CAPW-1:0];
          rem_q  <= dhi[DENW-1:0];
          den_q  <= DENW'(n2_q);
          dsat_q <= dsat_ld;
          step_q <= fose_pkg::STEPW'(fose_pkg::CAPW);
        end
      end
      fose_pkg::ST_DIV: begin
        rem_q  <= dge ? DENW'(dr2 - {1'b0, den_q}) : dr2[DENW-1:0];
        quo_q  <= {quo_q[fose_pkg::CAPW-2:0], dge};
        dsh_q  <= dsh_q << 1;
        step_q <= step_q - fose_pkg::STEPW'(1);
      end
      fose_pkg::ST_DIV_END: begin
        if (phase_q == fose_pkg::PH_EOFF) begin
          eoff_q <= quo_len;
        end else if (phase_q == fose_pkg::PH_ESPR) begin
          res_ok_q  <= 1'b1;
          res_off_q <= eoff_q;
          res_spr_q <= quo_len;
          res_cnt_q <= count_q;
        end else begin
          t_q <= dsat_q ? (TW'(1) << fose_pkg::CAPW) : TW'(quo_q);
        end
      end
      fose_pkg::ST_SQ_LD: begin
        sqv_q   <= t_q[fose_pkg::SQIW-1:0];
        sqrem_q <= '0;
        root_q  <= '0;
        step_q  <= fose_pkg::STEPW'(fose_pkg::ROOTW);
      end
      fose_pkg::ST_SQ: begin
        sqrem_q <= sge ? sr2 - strial : sr2;
        root_q  <= {root_q[fose_pkg::ROOTW-2:0], sge};
        sqv_q   <= sqv_q << 2;
        step_q  <= step_q - fose_pkg::STEPW'(1);
      end
      fose_pkg::ST_SQ_END: begin
        case (phase_q)
          fose_pkg::PH_OFF: off_q <= sat_root(root_q);
          fose_pkg::PH_VX:  sdx_q <= root_q;
          fose_pkg::PH_VY:  sdy_q <= root_q;
          default:          spr_q <= sat_root(root_q);
        endcase
      end
      fose_pkg::ST_ACC: begin
        res_ok_q  <= 1'b1;
        res_off_q <= off_q;
        res_spr_q <= spr_q;
        res_cnt_q <= cnt_room ? count_q + fose_pkg::CNTW'(1) : count_q;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire
